/* hw/rtl/actt_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// actt_pkg: shared types and constants
// Command codes, controller states, the captured request word and the
// fixed widths of the adaptive connect timeout table.
// ---------------------------------------------------------------------------
package actt_pkg;

  // field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned DUR_W     = 19;
  localparam int unsigned TIMEOUT_W = 18;
  localparam int unsigned FAIL_W    = 8;

  // defaults and limits
  localparam int unsigned ENTRIES_DEF     = 16;
  localparam logic [MS_W-1:0]   MAX_TIMEOUT_RST = 16'd10000;
  localparam logic [FAIL_W-1:0] FAIL_MAX        = 8'd255;

  // divide by 3 as multiply by ceil(2^21/3), exact for sums below 2^20
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned DIV3_SHIFT = 21;
  localparam logic [SUM_W-1:0] DIV3_MUL = 20'd699051;

  typedef enum logic [CMD_W-1:0] {
    CMD_SUGGEST   = 2'd0,
    CMD_CONN_OK   = 2'd1,
    CMD_PUB_OK    = 2'd2,
    CMD_CONN_FAIL = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // one captured request word
  typedef struct packed {
    cmd_t            cmd;
    logic [IDX_W-1:0] idx;
    logic [MS_W-1:0]  minimum;
    logic [MS_W-1:0]  duration;
  } item_t;

  // entry as read from the table
  typedef struct packed {
    logic                    valid;
    logic signed [DUR_W-1:0] data;
  } entry_t;

  // update decision for one entry
  typedef struct packed {
    logic                    we;
    logic signed [DUR_W-1:0] data;
    logic [TIMEOUT_W-1:0]    timeout;
  } upd_t;

endpackage

/* hw/rtl/actt_store.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// actt_store: duration table
// Synchronous single-port-read, single-port-write memory of signed
// durations plus per-entry valid flops cleared by reset.
// ---------------------------------------------------------------------------
module actt_store #(
  parameter int unsigned ENTRIES = actt_pkg::ENTRIES_DEF,
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            re,
  input  logic [AW-1:0]                   raddr,
  output actt_pkg::entry_t                rd,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic signed [actt_pkg::DUR_W-1:0] wdata
);
  import actt_pkg::*;

  logic signed [DUR_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0]      valid;
  logic signed [DUR_W-1:0] rdata;
  logic                    rvalid;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid <= valid[raddr];
      end
    end
  end

  assign rd.valid = rvalid;
  assign rd.data  = rdata;

endmodule

/* hw/rtl/actt_update.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// actt_update: entry update logic
// Computes the suggested timeout with backoff and the filtered duration
// for a connect success from the entry read out of the table.
// ---------------------------------------------------------------------------
module actt_update (
  input  actt_pkg::item_t                 item,
  input  logic                            in_range,
  input  actt_pkg::entry_t                ent,
  input  logic [actt_pkg::MS_W-1:0]       max_timeout,
  output actt_pkg::upd_t                  upd
);
  import actt_pkg::*;

  logic [TIMEOUT_W-1:0]    min3;
  logic                    neg;
  logic [DUR_W-1:0]        mag;
  logic [DUR_W+1:0]        t;
  logic [MS_W-1:0]         ans;
  logic signed [DUR_W-1:0] sug_data;
  logic [TIMEOUT_W-1:0]    sug_timeout;
  logic [DUR_W-1:0]        e;
  logic [SUM_W-1:0]        sum;
  logic [2*SUM_W-1:0]      prod;

  // three times the minimum
  assign min3 = {1'b0, item.minimum, 1'b0} + TIMEOUT_W'(item.minimum);

  // magnitude of the stored value times three
  assign neg = ent.data[DUR_W-1];
  assign mag = neg ? DUR_W'(-ent.data) : DUR_W'(ent.data);
  assign t   = {1'b0, mag, 1'b0} + (DUR_W+2)'(mag);

  // lower clamp first, then upper clamp
  always_comb begin
    if (t < (DUR_W+2)'(item.minimum)) begin
      ans = item.minimum;
    end else if (t > (DUR_W+2)'(max_timeout)) begin
      ans = max_timeout;
    end else begin
      ans = t[MS_W-1:0];
    end
  end

  // suggest: seed an empty entry or back off a filled one, sign kept
  always_comb begin
    if (!ent.valid) begin
      sug_data    = DUR_W'(0) - DUR_W'(min3);
      sug_timeout = min3;
    end else begin
      sug_data    = neg ? (DUR_W'(0) - DUR_W'(ans)) : DUR_W'(ans);
      sug_timeout = TIMEOUT_W'(ans);
    end
  end

  // success: (entry + 2*dur) / 3 via reciprocal multiply, dur for empty/neg entry
  assign e    = (!ent.valid || neg) ? DUR_W'(item.duration) : ent.data;
  assign sum  = SUM_W'(e) + {3'b000, item.duration, 1'b0};
  assign prod = sum * DIV3_MUL;

  // select by command
  always_comb begin
    upd.we      = 1'b0;
    upd.data    = sug_data;
    upd.timeout = '0;
    case (item.cmd)
      CMD_SUGGEST: begin
        upd.we = in_range;
        if (in_range) begin
          upd.timeout = sug_timeout;
        end
      end
      CMD_CONN_OK: begin
        upd.we   = in_range;
        upd.data = prod[DIV3_SHIFT +: DUR_W];
      end
      default: begin
        upd.we = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/adaptive_connect_timeout_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adaptive_connect_timeout_table: per-channel connect timeout table
// Suggests connect timeouts with backoff, filters measured connect
// durations and keeps a saturating failure counter.
// ---------------------------------------------------------------------------
// the input word and its table entry are registered on acceptance; the
// update, the write-back of the same entry and the result register follow
// in the execute state; no new word is accepted until execute completes
// a waiting result does not block acceptance of the next word, only its execute
// reset: valid bits and failure counter cleared, max timeout set to 10000,
//   no clearing pass over the table
module adaptive_connect_timeout_table #(
  parameter int unsigned ENTRIES = actt_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config: max_timeout_ms
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // entry_index[3:0], minimum_ms[19:4], conn_dur[35:20]
  input  logic [1:0]  s_tuser,  // cmd[1:0]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // timeout_ms[17:0], failure_count[25:18]
);
  import actt_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_t                  state;
  state_t                  state_next;
  item_t                   item;
  logic                    in_range;
  logic [MS_W-1:0]         max_timeout;
  logic [FAIL_W-1:0]       failures;
  logic [FAIL_W-1:0]       failures_next;
  logic [TIMEOUT_W-1:0]    out_timeout;
  logic                    accept;
  logic                    done;
  logic                    store_we;
  entry_t                  ent;
  upd_t                    upd;
  logic [IDX_W-1:0]        s_idx;

  assign s_idx  = s_tdata[IDX_W-1:0];
  assign accept = s_tvalid && s_tready;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_timeout <= MAX_TIMEOUT_RST;
    end else if (cfg_wen) begin
      max_timeout <= cfg_wdata;
    end
  end

  // capture request word
  always_ff @(posedge clk) begin
    if (accept) begin
      item.cmd      <= cmd_t'(s_tuser);
      item.idx      <= s_idx;
      item.minimum  <= s_tdata[IDX_W +: MS_W];
      item.duration <= s_tdata[IDX_W+MS_W +: MS_W];
      in_range      <= (32'(s_idx) < ENTRIES);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    done     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_EXEC: begin
        done = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // table
  actt_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .re    (accept),
    .raddr (AW'(s_idx)),
    .rd    (ent),
    .we    (store_we),
    .waddr (AW'(item.idx)),
    .wdata (upd.data)
  );

  // entry update
  actt_update u_update (
    .item        (item),
    .in_range    (in_range),
    .ent         (ent),
    .max_timeout (max_timeout),
    .upd         (upd)
  );

  assign store_we = done && upd.we;

  // failure counter
  always_comb begin
    failures_next = failures;
    case (item.cmd)
      CMD_CONN_OK, CMD_PUB_OK: begin
        if (failures != '0) begin
          failures_next = failures - 1'b1;
        end
      end
      CMD_CONN_FAIL: begin
        if (failures != FAIL_MAX) begin
          failures_next = failures + 1'b1;
        end
      end
      default: begin
        failures_next = failures;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failures <= '0;
    end else if (done) begin
      failures <= failures_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_timeout <= upd.timeout;
    end
  end

  assign m_tdata = {6'b0, failures, out_timeout};

  // checks
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC) && !s_tready)
    else $error("accepted word did not enter execute");

  a_we_in_exec: assert property (@(posedge clk) disable iff (rst)
    store_we |-> (state == ST_EXEC) && in_range)
    else $error("table write outside execute or out of range");

  a_fail_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && (item.cmd == CMD_CONN_FAIL)) |=> (m_tdata[25:18] != 8'd0))
    else $error("failure count zero after connect failure");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (item.cmd != CMD_SUGGEST)) |=> (m_tdata[17:0] == 18'd0))
    else $error("nonzero timeout for non-suggest word");

endmodule
